// ===== hw/rtl/lcss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcss_pkg
// Shared widths, codes and controller/datapath interface types of the
// linear congruence system solver.
// ----------------------------------------------------------------------------
package lcss_pkg;

  localparam int VB        = 40;            // value width
  localparam int AB        = VB + 1;        // answer width
  localparam int CNT_BITS  = $clog2(VB + 1);

  localparam logic [VB-1:0] VALUE_MASK = '1;

  localparam logic [1:0] ST_SOLVED      = 2'd0;
  localparam logic [1:0] ST_NO_SOLUTION = 2'd1;
  localparam logic [1:0] ST_OVERFLOW    = 2'd2;

  typedef enum logic [5:0] {
    OP_IDLE, OP_START, OP_LB0, OP_LB, OP_CMOD, OP_AMOD, OP_SETFAIL,
    OP_GINIT, OP_GSTEP, OP_AG, OP_PR, OP_CG, OP_CGM, OP_INV1INIT,
    OP_IDIV, OP_IQMOD, OP_IMUL, OP_IUPD, OP_R, OP_G2INIT, OP_RD1, OP_RD2,
    OP_MDIV, OP_LIM, OP_M2, OP_RP, OP_T, OP_TD, OP_MDM, OP_INV2INIT,
    OP_K, OP_MK, OP_RUP, OP_MUP, OP_GAP, OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    CS_IDLE, CS_ISSUE, CS_WAIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic go;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic c_zero;
    logic a_zero;
    logic y_zero;
    logic fail;
    logic ovf;
    logic last;
    logic lt;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/linear_congruence_system_solver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_congruence_system_solver
// Solves systems of congruences c*x = a (mod p) by extended CRT merging.
// ----------------------------------------------------------------------------
// Each input transaction carries one congruence; the transaction flagged
// last_of_system yields one result transaction (least solution at or above
// the largest ceil(a/c), or a no-solution / modulus-overflow status) and
// returns the running system to its empty state. One congruence is worked
// at a time. Every divide and every modular multiply runs on one shared
// 40-step divider or one 40-step bit-serial multiplier. A congruence costs
// roughly 20 + G1 + G2 + 3 * (E1 + E2) divides and multiplies, where G1/G2
// are the Euclid steps of the two gcds and E1/E2 those of the two modular
// inverses. Sticky failures cut the work to at most one divide. A new input
// is taken while a finished result still waits on the output register.
// ----------------------------------------------------------------------------
module linear_congruence_system_solver (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [lcss_pkg::VB-1:0] in_coefficient,
  input  logic [lcss_pkg::VB-1:0] in_target,
  input  logic [lcss_pkg::VB-1:0] in_modulus,
  input  logic                    in_last_of_system,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [lcss_pkg::AB-1:0] out_answer,
  output logic [1:0]              out_status
);

  lcss_pkg::cmd_t  cmd;
  lcss_pkg::stat_t stat;

  // sequencer: one command in flight, branch on datapath status
  lcss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // registers, divider, multiplier and the output register
  lcss_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_coefficient    (in_coefficient),
    .in_target         (in_target),
    .in_modulus        (in_modulus),
    .in_last_of_system (in_last_of_system),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_answer        (out_answer),
    .out_status        (out_status)
  );

  // a failed or overflowed system reports a zero answer
  a_err_answer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != lcss_pkg::ST_SOLVED) |-> (out_answer == '0))
    else $error("error status with nonzero answer");

  // after accepting a transaction, no other is taken in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a congruence is in work");

  // a result only appears through a command issue while the slot was free
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.go && cmd.op == lcss_pkg::OP_EMIT) |-> stat.out_free)
    else $error("result written over a pending result");

endmodule

// ===== hw/rtl/lcss_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcss_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcss_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [lcss_pkg::VB-1:0] num,
  input  logic [lcss_pkg::VB-1:0] den,
  output logic                    done,
  output logic [lcss_pkg::VB-1:0] quo,
  output logic [lcss_pkg::VB-1:0] rem
);

  logic                          busy_r;
  logic                          done_r;
  logic [lcss_pkg::CNT_BITS-1:0] cnt_r;
  logic [lcss_pkg::VB-1:0]       n_r;
  logic [lcss_pkg::VB-1:0]       d_r;
  logic [lcss_pkg::VB-1:0]       rem_r;
  logic [lcss_pkg::VB:0]         trial;
  logic                          fits;

  assign trial = {rem_r, n_r[lcss_pkg::VB-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        n_r    <= num;
        d_r    <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        // shift in one numerator bit, subtract when it fits
        rem_r <= fits ? trial[lcss_pkg::VB-1:0] - d_r : trial[lcss_pkg::VB-1:0];
        n_r   <= {n_r[lcss_pkg::VB-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == lcss_pkg::CNT_BITS'(lcss_pkg::VB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = n_r;
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/lcss_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcss_mulmod
// Bit-serial modular multiplier: a*b mod m, one multiplier bit per cycle.
// Operands must already be below m.
// ----------------------------------------------------------------------------
module lcss_mulmod (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [lcss_pkg::VB-1:0] a,
  input  logic [lcss_pkg::VB-1:0] b,
  input  logic [lcss_pkg::VB:0]   m,
  output logic                    done,
  output logic [lcss_pkg::VB:0]   prod
);

  logic                          busy_r;
  logic                          done_r;
  logic [lcss_pkg::CNT_BITS-1:0] cnt_r;
  logic [lcss_pkg::VB:0]         a_r;
  logic [lcss_pkg::VB-1:0]       b_r;
  logic [lcss_pkg::VB:0]         m_r;
  logic [lcss_pkg::VB:0]         p_r;
  logic [lcss_pkg::VB+1:0]       sum_p;
  logic [lcss_pkg::VB+1:0]       sum_a;
  logic [lcss_pkg::VB:0]         red_p;
  logic [lcss_pkg::VB:0]         red_a;

  always_comb begin
    sum_p = {1'b0, p_r} + {1'b0, a_r};
    sum_a = {1'b0, a_r} + {1'b0, a_r};
    red_p = (sum_p >= {1'b0, m_r}) ? lcss_pkg::AB'(sum_p - {1'b0, m_r})
                                   : lcss_pkg::AB'(sum_p);
    red_a = (sum_a >= {1'b0, m_r}) ? lcss_pkg::AB'(sum_a - {1'b0, m_r})
                                   : lcss_pkg::AB'(sum_a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= {1'b0, a};
        b_r    <= b;
        m_r    <= m;
        p_r    <= '0;
      end else if (busy_r) begin
        if (b_r[0]) begin
          p_r <= red_p;
        end
        a_r   <= red_a;
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == lcss_pkg::CNT_BITS'(lcss_pkg::VB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

// ===== hw/rtl/lcss_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcss_datapath
// Working registers, system state, shared divider and modular multiplier,
// and the result register. Executes one controller command at a time.
// ----------------------------------------------------------------------------
module lcss_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lcss_pkg::cmd_t          cmd,
  output lcss_pkg::stat_t         stat,
  input  logic [lcss_pkg::VB-1:0] in_coefficient,
  input  logic [lcss_pkg::VB-1:0] in_target,
  input  logic [lcss_pkg::VB-1:0] in_modulus,
  input  logic                    in_last_of_system,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [lcss_pkg::AB-1:0] out_answer,
  output logic [1:0]              out_status
);

  localparam int VB = lcss_pkg::VB;
  localparam int AB = lcss_pkg::AB;

  logic [VB-1:0] c_r, a_r, p_r, x_r, y_r, q_r, t_r, nt_r, im_r;
  logic [VB-1:0] pr_r, d_r, md_r, m2_r, rr_r;
  logic [AB-1:0] tmp_r;
  logic [VB-1:0] res_r, mod_r, lb_r;
  logic          last_r, fail_r, ovf_r, done_r, out_valid_r;
  logic [AB-1:0] out_answer_r;
  logic [1:0]    out_status_r;

  logic          div_start, div_done, mul_start, mul_done;
  logic [VB-1:0] div_n, div_d, div_q, div_rem;
  logic [VB-1:0] mul_a, mul_b;
  logic [AB-1:0] mul_m, mul_p;
  logic          is_div, is_mul;
  logic [AB-1:0] lb_cand;
  logic [AB-1:0] upd_sum, t_sum;
  logic [VB-1:0] upd_red, t_red;

  // operand selection per command
  always_comb begin
    is_div = 1'b1;
    div_n  = a_r;
    div_d  = c_r;
    unique case (cmd.op)
      lcss_pkg::OP_LB:    begin div_n = a_r;   div_d = c_r;  end
      lcss_pkg::OP_CMOD:  begin div_n = c_r;   div_d = p_r;  end
      lcss_pkg::OP_AMOD:  begin div_n = a_r;   div_d = p_r;  end
      lcss_pkg::OP_GSTEP,
      lcss_pkg::OP_IDIV:  begin div_n = x_r;   div_d = y_r;  end
      lcss_pkg::OP_AG:    begin div_n = a_r;   div_d = x_r;  end
      lcss_pkg::OP_PR:    begin div_n = p_r;   div_d = x_r;  end
      lcss_pkg::OP_CG:    begin div_n = c_r;   div_d = x_r;  end
      lcss_pkg::OP_CGM:   begin div_n = c_r;   div_d = pr_r; end
      lcss_pkg::OP_IQMOD: begin div_n = q_r;   div_d = im_r; end
      lcss_pkg::OP_RD1:   begin div_n = res_r; div_d = x_r;  end
      lcss_pkg::OP_RD2:   begin div_n = rr_r;  div_d = x_r;  end
      lcss_pkg::OP_MDIV:  begin div_n = mod_r; div_d = d_r;  end
      lcss_pkg::OP_LIM:   begin div_n = lcss_pkg::VALUE_MASK; div_d = pr_r; end
      lcss_pkg::OP_M2:    begin div_n = pr_r;  div_d = d_r;  end
      lcss_pkg::OP_RP:    begin div_n = res_r; div_d = pr_r; end
      lcss_pkg::OP_TD:    begin div_n = tmp_r[VB-1:0]; div_d = d_r; end
      lcss_pkg::OP_MDM:   begin div_n = md_r;  div_d = m2_r; end
      lcss_pkg::OP_GAP:   begin div_n = lb_r - res_r; div_d = mod_r; end
      default:            is_div = 1'b0;
    endcase
  end

  always_comb begin
    is_mul = 1'b1;
    mul_a  = q_r;
    mul_b  = nt_r;
    mul_m  = {1'b0, im_r};
    unique case (cmd.op)
      lcss_pkg::OP_IMUL: begin mul_a = q_r;   mul_b = nt_r; mul_m = {1'b0, im_r}; end
      lcss_pkg::OP_R:    begin mul_a = a_r;   mul_b = t_r;  mul_m = {1'b0, pr_r}; end
      lcss_pkg::OP_K:    begin mul_a = a_r;   mul_b = t_r;  mul_m = {1'b0, m2_r}; end
      // exact products: modulus 2^VB never binds
      lcss_pkg::OP_MK:   begin
        mul_a = mod_r; mul_b = tmp_r[VB-1:0]; mul_m = {1'b1, {VB{1'b0}}};
      end
      lcss_pkg::OP_MUP:  begin
        mul_a = md_r;  mul_b = pr_r;          mul_m = {1'b1, {VB{1'b0}}};
      end
      default:           is_mul = 1'b0;
    endcase
  end

  assign div_start = cmd.go & is_div;
  assign mul_start = cmd.go & is_mul;

  lcss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_rem)
  );

  lcss_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (mul_m),
    .done  (mul_done),
    .prod  (mul_p)
  );

  always_comb begin
    lb_cand = {1'b0, div_q} + AB'(div_rem != '0);
    upd_sum = {1'b0, t_r} + {1'b0, im_r} - tmp_r;
    upd_red = (upd_sum >= {1'b0, im_r}) ? VB'(upd_sum - {1'b0, im_r}) : VB'(upd_sum);
    t_sum   = {1'b0, rr_r} + {1'b0, pr_r} - tmp_r;
    t_red   = (t_sum >= {1'b0, pr_r}) ? VB'(t_sum - {1'b0, pr_r}) : VB'(t_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r       <= '0;
      mod_r       <= VB'(1);
      lb_r        <= '0;
      fail_r      <= 1'b0;
      ovf_r       <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      done_r <= div_done | mul_done | (cmd.go & ~is_div & ~is_mul);
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        c_r    <= in_coefficient;
        a_r    <= in_target;
        p_r    <= (in_modulus == '0) ? VB'(1) : in_modulus;
        last_r <= in_last_of_system;
      end
      // commands that use neither the divider nor the multiplier
      if (cmd.go) begin
        unique case (cmd.op)
          lcss_pkg::OP_LB0: begin
            if (a_r > lb_r) lb_r <= a_r;
          end
          lcss_pkg::OP_SETFAIL: fail_r <= 1'b1;
          lcss_pkg::OP_GINIT: begin
            x_r <= p_r;
            y_r <= c_r;
          end
          lcss_pkg::OP_INV1INIT: begin
            im_r <= pr_r;
            x_r  <= pr_r;
            y_r  <= c_r;
            t_r  <= '0;
            nt_r <= VB'(1);
          end
          lcss_pkg::OP_INV2INIT: begin
            im_r <= m2_r;
            x_r  <= m2_r;
            y_r  <= c_r;
            t_r  <= '0;
            nt_r <= VB'(1);
          end
          lcss_pkg::OP_IUPD: begin
            t_r  <= nt_r;
            nt_r <= upd_red;
          end
          lcss_pkg::OP_G2INIT: begin
            x_r <= mod_r;
            y_r <= pr_r;
          end
          lcss_pkg::OP_T:   tmp_r <= {1'b0, t_red};
          lcss_pkg::OP_RUP: res_r <= res_r + tmp_r[VB-1:0];
          lcss_pkg::OP_EMIT: begin
            out_valid_r <= 1'b1;
            if (fail_r) begin
              out_answer_r <= '0;
              out_status_r <= lcss_pkg::ST_NO_SOLUTION;
            end else if (ovf_r) begin
              out_answer_r <= '0;
              out_status_r <= lcss_pkg::ST_OVERFLOW;
            end else begin
              out_answer_r <= (res_r < lb_r) ? tmp_r : {1'b0, res_r};
              out_status_r <= lcss_pkg::ST_SOLVED;
            end
            res_r  <= '0;
            mod_r  <= VB'(1);
            lb_r   <= '0;
            fail_r <= 1'b0;
            ovf_r  <= 1'b0;
          end
          default: ;
        endcase
      end
      // divider write-back
      if (div_done) begin
        unique case (cmd.op)
          lcss_pkg::OP_LB: begin
            if (lb_cand > {1'b0, lb_r}) lb_r <= lb_cand[VB-1:0];
          end
          lcss_pkg::OP_CMOD:  c_r <= div_rem;
          lcss_pkg::OP_AMOD:  a_r <= div_rem;
          lcss_pkg::OP_GSTEP: begin
            x_r <= y_r;
            y_r <= div_rem;
          end
          lcss_pkg::OP_AG: begin
            a_r <= div_q;
            if (div_rem != '0) fail_r <= 1'b1;
          end
          lcss_pkg::OP_PR:  pr_r <= div_q;
          lcss_pkg::OP_CG:  c_r  <= div_q;
          lcss_pkg::OP_CGM: c_r  <= div_rem;
          lcss_pkg::OP_IDIV: begin
            q_r <= div_q;
            x_r <= y_r;
            y_r <= div_rem;
          end
          lcss_pkg::OP_IQMOD: q_r <= div_rem;
          lcss_pkg::OP_RD1: begin
            tmp_r <= {1'b0, div_rem};
            d_r   <= x_r;
          end
          lcss_pkg::OP_RD2: begin
            if ({1'b0, div_rem} != tmp_r) fail_r <= 1'b1;
          end
          lcss_pkg::OP_MDIV: md_r <= div_q;
          lcss_pkg::OP_LIM: begin
            if (md_r > div_q) ovf_r <= 1'b1;
          end
          lcss_pkg::OP_M2:  m2_r  <= div_q;
          lcss_pkg::OP_RP:  tmp_r <= {1'b0, div_rem};
          lcss_pkg::OP_TD:  a_r   <= div_q;
          lcss_pkg::OP_MDM: c_r   <= div_rem;
          lcss_pkg::OP_GAP: begin
            tmp_r <= {1'b0, lb_r} +
                     ((div_rem == '0) ? '0 : {1'b0, mod_r - div_rem});
          end
          default: ;
        endcase
      end
      // multiplier write-back
      if (mul_done) begin
        unique case (cmd.op)
          lcss_pkg::OP_IMUL: tmp_r <= mul_p;
          lcss_pkg::OP_R:    rr_r  <= mul_p[VB-1:0];
          lcss_pkg::OP_K:    tmp_r <= mul_p;
          lcss_pkg::OP_MK:   tmp_r <= mul_p;
          lcss_pkg::OP_MUP:  mod_r <= mul_p[VB-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    stat.done     = done_r;
    stat.c_zero   = (c_r == '0);
    stat.a_zero   = (a_r == '0);
    stat.y_zero   = (y_r == '0);
    stat.fail     = fail_r;
    stat.ovf      = ovf_r;
    stat.last     = last_r;
    stat.lt       = (res_r < lb_r);
    stat.out_free = ~out_valid_r;
  end

  assign out_valid  = out_valid_r;
  assign out_answer = out_answer_r;
  assign out_status = out_status_r;

endmodule

// ===== hw/rtl/lcss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcss_ctrl
// Sequencer: walks the per-congruence command list, branching on datapath
// status, and issues one command at a time.
// ----------------------------------------------------------------------------
module lcss_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lcss_pkg::stat_t stat,
  output lcss_pkg::cmd_t  cmd
);

  lcss_pkg::ctrl_state_t state_r, state_nxt;
  lcss_pkg::op_t         op_r, op_nxt, op_after;
  logic                  sec_r, sec_nxt;

  function automatic lcss_pkg::op_t finish_op(lcss_pkg::stat_t s);
    if (!s.last)                  return lcss_pkg::OP_IDLE;
    else if (s.fail || s.ovf || !s.lt) return lcss_pkg::OP_EMIT;
    else                          return lcss_pkg::OP_GAP;
  endfunction

  // successor of the command that just completed
  always_comb begin
    unique case (op_r)
      lcss_pkg::OP_START:   op_after = stat.c_zero ? lcss_pkg::OP_LB0 : lcss_pkg::OP_LB;
      lcss_pkg::OP_LB0,
      lcss_pkg::OP_LB:      op_after = (stat.fail || stat.ovf) ? finish_op(stat)
                                                               : lcss_pkg::OP_CMOD;
      lcss_pkg::OP_CMOD:    op_after = lcss_pkg::OP_AMOD;
      lcss_pkg::OP_AMOD:    op_after = !stat.c_zero ? lcss_pkg::OP_GINIT :
                                       stat.a_zero  ? finish_op(stat) : lcss_pkg::OP_SETFAIL;
      lcss_pkg::OP_SETFAIL: op_after = finish_op(stat);
      lcss_pkg::OP_GINIT,
      lcss_pkg::OP_G2INIT,
      lcss_pkg::OP_GSTEP:   op_after = !stat.y_zero ? lcss_pkg::OP_GSTEP :
                                       sec_r ? lcss_pkg::OP_RD1 : lcss_pkg::OP_AG;
      lcss_pkg::OP_AG:      op_after = stat.fail ? finish_op(stat) : lcss_pkg::OP_PR;
      lcss_pkg::OP_PR:      op_after = lcss_pkg::OP_CG;
      lcss_pkg::OP_CG:      op_after = lcss_pkg::OP_CGM;
      lcss_pkg::OP_CGM:     op_after = lcss_pkg::OP_INV1INIT;
      lcss_pkg::OP_INV1INIT,
      lcss_pkg::OP_INV2INIT,
      lcss_pkg::OP_IUPD:    op_after = !stat.y_zero ? lcss_pkg::OP_IDIV :
                                       sec_r ? lcss_pkg::OP_K : lcss_pkg::OP_R;
      lcss_pkg::OP_IDIV:    op_after = lcss_pkg::OP_IQMOD;
      lcss_pkg::OP_IQMOD:   op_after = lcss_pkg::OP_IMUL;
      lcss_pkg::OP_IMUL:    op_after = lcss_pkg::OP_IUPD;
      lcss_pkg::OP_R:       op_after = lcss_pkg::OP_G2INIT;
      lcss_pkg::OP_RD1:     op_after = lcss_pkg::OP_RD2;
      lcss_pkg::OP_RD2:     op_after = stat.fail ? finish_op(stat) : lcss_pkg::OP_MDIV;
      lcss_pkg::OP_MDIV:    op_after = lcss_pkg::OP_LIM;
      lcss_pkg::OP_LIM:     op_after = stat.ovf ? finish_op(stat) : lcss_pkg::OP_M2;
      lcss_pkg::OP_M2:      op_after = lcss_pkg::OP_RP;
      lcss_pkg::OP_RP:      op_after = lcss_pkg::OP_T;
      lcss_pkg::OP_T:       op_after = lcss_pkg::OP_TD;
      lcss_pkg::OP_TD:      op_after = lcss_pkg::OP_MDM;
      lcss_pkg::OP_MDM:     op_after = lcss_pkg::OP_INV2INIT;
      lcss_pkg::OP_K:       op_after = lcss_pkg::OP_MK;
      lcss_pkg::OP_MK:      op_after = lcss_pkg::OP_RUP;
      lcss_pkg::OP_RUP:     op_after = lcss_pkg::OP_MUP;
      lcss_pkg::OP_MUP:     op_after = finish_op(stat);
      lcss_pkg::OP_GAP:     op_after = lcss_pkg::OP_EMIT;
      default:              op_after = lcss_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcss_pkg::CS_IDLE;
      op_r    <= lcss_pkg::OP_IDLE;
      sec_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      sec_r   <= sec_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    sec_nxt   = sec_r;
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.go    = 1'b0;
    cmd.op    = op_r;
    unique case (state_r)
      lcss_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          op_nxt    = lcss_pkg::OP_START;
          sec_nxt   = 1'b0;
          state_nxt = lcss_pkg::CS_ISSUE;
        end
      end
      lcss_pkg::CS_ISSUE: begin
        // hold the result command until the output slot is free
        if (op_r != lcss_pkg::OP_EMIT || stat.out_free) begin
          cmd.go    = 1'b1;
          state_nxt = lcss_pkg::CS_WAIT;
          if (op_r == lcss_pkg::OP_G2INIT) sec_nxt = 1'b1;
        end
      end
      lcss_pkg::CS_WAIT: begin
        if (stat.done) begin
          op_nxt    = op_after;
          state_nxt = (op_after == lcss_pkg::OP_IDLE) ? lcss_pkg::CS_IDLE
                                                      : lcss_pkg::CS_ISSUE;
        end
      end
      default: state_nxt = lcss_pkg::CS_IDLE;
    endcase
  end

endmodule
